[hdl/chsq_pkg.sv]
// chsq_pkg: constants, command/status structs and exp fraction table
// for the chi-square histogram likelihood block; no dependencies
`timescale 1ns / 1ps
package chsq_pkg;
    localparam int MAX_BINS_DEF        = 4096;
    localparam int EXP_TABLE_DEPTH_DEF = 256;
    localparam int ACC_W               = 28;
    localparam int BIN_W               = 16;
    localparam int GAIN_W              = 16;
    localparam int GSIZE_W             = 11;
    localparam int CNT_W               = 10;
    localparam int CFG_IDX_W           = 1;
    localparam int DIV_STEPS           = 32;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GSIZE = 1'd1;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;

    typedef struct packed {
        logic load;      // latch input item, start divider
        logic step;      // one divider step
        logic accum;     // add term to accumulators
        logic exp_mul1;  // gain * distance
        logic exp_mul2;  // * log2(e)
        logic exp_fin;   // table lookup and shift into output register
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic last;
    } stat_t;

    // shift and subtract long division, used only to build the table
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // 2^(-i/depth) * 65535, rounded, from a 16-term series for exp(-u) in Q.32
    function automatic logic [15:0] exp_entry(input int i, input int depth);
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] s;
        logic [63:0] term;
        logic [63:0] e;
        t    = udiv64({32'(i), 32'd0}, 64'(depth));
        u    = (t * LN2_Q32) >> 32;
        s    = ONE_Q32;
        term = ONE_Q32;
        for (int k = 1; k <= 16; k++)
        begin
            term = udiv64((term * u) >> 32, 64'(k));
            if ((k & 1) != 0)
                s = s - term;
            else
                s = s + term;
        end
        e = (64'd65535 * s + 64'h8000_0000) >> 32;
        if (e > 64'd65535)
            e = 64'd65535;
        return e[15:0];
    endfunction
endpackage

[hdl/chsq_ctrl.sv]
// chsq_ctrl: sequencer for one item (divide, accumulate, exponent)
// depends on chsq_pkg
`timescale 1ns / 1ps
module chsq_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output chsq_pkg::cmd_t  cmd,
    input  chsq_pkg::stat_t stat
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_M1   = 3'd3;
    localparam logic [2:0] ST_M2   = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    assign out_valid = ovalid_reg;
    // a waiting result blocks only the final write into the output register
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        ovalid_next = ovalid_reg && out_stall;
        cmd         = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (stat.div_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = stat.last ? ST_M1 : ST_IDLE;
            end
            ST_M1:
            begin
                cmd.exp_mul1 = 1'b1;
                state_next   = ST_M2;
            end
            ST_M2:
            begin
                cmd.exp_mul2 = 1'b1;
                state_next   = ST_FIN;
            end
            ST_FIN:
            begin
                if (!ovalid_next)
                begin
                    cmd.exp_fin = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

`ifndef SYNTHESIS
    a_fin_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exp_fin |-> !(ovalid_reg && out_stall))
        else $error("result overwritten");
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == ST_IDLE)
        else $error("load outside idle");
`endif
endmodule

[hdl/chsq_dp.sv]
// chsq_dp: serial divider, saturating accumulators, exponent datapath
// depends on chsq_pkg
`timescale 1ns / 1ps
module chsq_dp #(
    parameter int EXP_TABLE_DEPTH = chsq_pkg::EXP_TABLE_DEPTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  chsq_pkg::cmd_t                cmd,
    output chsq_pkg::stat_t               stat,
    input  logic [chsq_pkg::BIN_W-1:0]    measured_bin,
    input  logic [chsq_pkg::BIN_W-1:0]    predicted_bin,
    input  logic                          last_bin,
    input  logic [chsq_pkg::GAIN_W-1:0]   gain,
    input  logic [chsq_pkg::GSIZE_W-1:0]  group_size,
    output logic [chsq_pkg::ACC_W-1:0]    distance,
    output logic [15:0]                   weight,
    output logic                          saturated
);
    localparam int TW = $clog2(EXP_TABLE_DEPTH);
    localparam int AW = chsq_pkg::ACC_W;

    logic [15:0] frac_table [EXP_TABLE_DEPTH];
    always_comb
    begin
        for (int i = 0; i < EXP_TABLE_DEPTH; i++)
            frac_table[i] = chsq_pkg::exp_entry(i, EXP_TABLE_DEPTH);
    end

    // restoring divider: d*d (32 bit) over s (17 bit)
    logic [31:0] quo_reg;
    logic [16:0] rem_reg, den_reg;
    logic [5:0]  cnt_reg;
    logic        last_reg;
    logic [15:0] diff;
    logic [17:0] trial;
    assign diff  = (measured_bin > predicted_bin) ?
                   (measured_bin - predicted_bin) : (predicted_bin - measured_bin);
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            quo_reg  <= diff * diff;
            rem_reg  <= '0;
            den_reg  <= 17'(measured_bin) + 17'(predicted_bin);
            cnt_reg  <= '0;
            last_reg <= last_bin;
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!trial[17])
            begin
                rem_reg <= trial[16:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[15:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end
    assign stat.div_done = (cnt_reg == 6'(chsq_pkg::DIV_STEPS - 1));
    assign stat.last     = last_reg;

    logic [AW-1:0] term;
    assign term = (den_reg == '0) ? '0 : AW'(quo_reg[15:0]);

    logic [AW-1:0] group_sum_reg, total_sum_reg;
    logic [9:0]    bin_reg;
    logic          ovf_reg;
    logic [AW:0]   gsum, tsum;
    logic [AW-1:0] gsat;
    logic [10:0]   gclamp, count;
    assign gsum   = {1'b0, group_sum_reg} + {1'b0, term};
    assign gsat   = gsum[AW] ? chsq_pkg::ACC_MAX : gsum[AW-1:0];
    assign tsum   = {1'b0, total_sum_reg} + {1'b0, gsat};
    assign gclamp = (group_size == '0) ? 11'd1 : (group_size > 11'd1024) ? 11'd1024 : group_size;
    assign count  = {1'b0, bin_reg} + 11'd1;

    logic [AW-1:0] dist_reg;
    logic          sat_reg;
    logic [AW-1:0] tot_new;
    logic          ovf_new;
    always_comb
    begin
        tot_new = total_sum_reg;
        ovf_new = ovf_reg | gsum[AW];
        if (count >= gclamp)
        begin
            tot_new = tsum[AW] ? chsq_pkg::ACC_MAX : tsum[AW-1:0];
            ovf_new = ovf_new | tsum[AW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_sum_reg <= '0;
            total_sum_reg <= '0;
            bin_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else if (cmd.accum)
        begin
            if (last_reg)
            begin
                group_sum_reg <= '0;
                total_sum_reg <= '0;
                bin_reg       <= '0;
                ovf_reg       <= 1'b0;
            end
            else
            begin
                total_sum_reg <= tot_new;
                ovf_reg       <= ovf_new;
                if (count >= gclamp)
                begin
                    group_sum_reg <= '0;
                    bin_reg       <= '0;
                end
                else
                begin
                    group_sum_reg <= gsat;
                    bin_reg       <= count[9:0];
                end
            end
        end
    end

    // exponent pipeline
    logic [43:0] x_reg;
    logic [27:0] xs;
    logic        x_big;
    logic [44:0] y_reg;
    assign xs    = x_reg[35:8];
    // x of 2^28 or more drives the weight to zero
    assign x_big = |x_reg[43:36];
    always_ff @(posedge clk)
    begin
        if (cmd.accum && last_reg)
        begin
            dist_reg <= tot_new;
            sat_reg  <= ovf_new;
        end
        if (cmd.exp_mul1)
            x_reg <= gain * dist_reg;
        if (cmd.exp_mul2)
            y_reg <= xs * chsq_pkg::LOG2E_Q16;
    end

    logic [28:0] y;
    logic [12:0] n;
    logic [TW-1:0] idx;
    assign y   = y_reg[44:16];
    assign n   = y[28:16];
    assign idx = y[15:16-TW];

    always_ff @(posedge clk)
    begin
        if (cmd.exp_fin)
        begin
            distance  <= dist_reg;
            saturated <= sat_reg;
            weight    <= (x_big || n >= 13'd16) ? 16'd0 : (frac_table[idx] >> n[3:0]);
        end
    end

`ifndef SYNTHESIS
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cnt_reg == '0)
        else $error("divider not restarted");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |=> bin_reg < 10'd1023 || bin_reg == 10'd1023)
        else $error("bin count");
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accum |-> quo_reg[31:17] == '0 || den_reg == '0)
        else $error("term too large");
`endif
endmodule

[hdl/chi_square_histogram_likelihood.sv]
// chi_square_histogram_likelihood: top level, config registers and the
// controller/datapath pair; depends on chsq_pkg, chsq_ctrl, chsq_dp
//
// one item = one measured and one predicted bin; an item with last_bin
// set yields one result (distance, weight, saturated)
// in channel: in_valid/in_stall, out channel: out_valid/out_stall
// each item is loaded while idle, then takes 32 restoring divider steps
// and one accumulate; the serial divider sets the rate and no new item is
// taken before the last is through; a last bin adds the exponent (two
// registered multiplies and a table lookup) before its result enters the
// output register; a result waits there while out_stall is high; the
// next item is taken meanwhile, and only a following result waits
// config (cfg_we, cfg_index, cfg_data) must be written by the user only
// while idle; the block itself does not enforce it
// reset clears accumulators and sets gain 256, group_size 8
// the fraction table is constant logic, no fill pass is needed
`timescale 1ns / 1ps
module chi_square_histogram_likelihood #(
    parameter int EXP_TABLE_DEPTH = chsq_pkg::EXP_TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] measured_bin,
    input  logic [15:0] predicted_bin,
    input  logic        last_bin,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [27:0] distance,
    output logic [15:0] weight,
    output logic        saturated,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [15:0] gain_reg;
    logic [10:0] gsize_reg;
    chsq_pkg::cmd_t  cmd;
    chsq_pkg::stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 16'd256;
            gsize_reg <= 11'd8;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                chsq_pkg::REG_GAIN:  gain_reg  <= cfg_data;
                chsq_pkg::REG_GSIZE: gsize_reg <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    chsq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
    );

    chsq_dp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .measured_bin(measured_bin), .predicted_bin(predicted_bin),
        .last_bin(last_bin), .gain(gain_reg), .group_size(gsize_reg),
        .distance(distance), .weight(weight), .saturated(saturated)
    );
endmodule
